/* rtl/whvg_pkg.sv */
package whvg_pkg;

    // Grid and table sizes.
    localparam int GRID_COLS       = 64;
    localparam int GRID_ROWS       = 64;
    localparam int CELL_SIZE_X     = 16;
    localparam int CELL_SIZE_Z     = 16;
    localparam int COS_TABLE_DEPTH = 256;

    // Field widths.
    localparam int COL_W   = 7;
    localparam int ROW_W   = 7;
    localparam int TIME_W  = 32;
    localparam int POS_W   = 16;
    localparam int Y_W     = 17;
    localparam int AMP_W   = 15;
    localparam int K_W     = 20;
    localparam int PHASE_W = 16;
    localparam int FRAC_W  = 14;
    localparam int COS_W   = 16;
    localparam int COSS_W  = COS_W + 1;
    localparam int PROD_W  = AMP_W + 1 + COSS_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int Y_SHIFT = 15;
    localparam int ROUND_HALF = 16384;

    // Position arithmetic before saturation.
    localparam int XCALC_W = 20;

    // The phase keeps 16 of the 20 fraction bits of the spatial sum.
    localparam int SPACE_SHIFT = K_W - PHASE_W;

    // Table index arithmetic.
    localparam int IDX_W  = $clog2(COS_TABLE_DEPTH + 1);
    localparam int IDXP_W = FRAC_W + IDX_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Register stages from input to output register.
    localparam int PIPE_STAGES = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMPLITUDE_FIRST    = 3'd0,
        REG_AMPLITUDE_SECOND   = 3'd1,
        REG_DIRECTION_X_FIRST  = 3'd2,
        REG_DIRECTION_Z_FIRST  = 3'd3,
        REG_DIRECTION_X_SECOND = 3'd4,
        REG_DIRECTION_Z_SECOND = 3'd5,
        REG_SPEED_FIRST        = 3'd6,
        REG_SPEED_SECOND       = 3'd7
    } cfg_reg_t;

    localparam logic [AMP_W-1:0]      RST_AMPLITUDE_FIRST    = 15'd512;
    localparam logic [AMP_W-1:0]      RST_AMPLITUDE_SECOND   = 15'd512;
    localparam logic signed [K_W-1:0] RST_DIRECTION_X_FIRST  = 20'sd10430;
    localparam logic signed [K_W-1:0] RST_DIRECTION_Z_FIRST  = 20'sd10430;
    localparam logic signed [K_W-1:0] RST_DIRECTION_X_SECOND = 20'sd10430;
    localparam logic signed [K_W-1:0] RST_DIRECTION_Z_SECOND = 20'sd0;
    localparam logic signed [K_W-1:0] RST_SPEED_FIRST        = 20'sd10923;
    localparam logic signed [K_W-1:0] RST_SPEED_SECOND       = 20'sd21845;

    // Quarter-wave cosine table in unsigned Q1.15, built at elaboration from a
    // Taylor series in Q30 with every term truncated.
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    typedef logic [COS_W-1:0] cos_table_t [0:COS_TABLE_DEPTH];

    // Quotient of a non-negative numerator by a positive divisor, by shift and
    // subtract. It only runs while the table is built at elaboration.
    function automatic longint div_floor(longint num, longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    function automatic cos_table_t build_cos_table();
        cos_table_t tbl;
        longint     ang;
        longint     ang2;
        longint     term;
        longint     sum;
        longint     den;
        for (int n = 0; n <= COS_TABLE_DEPTH; n++)
        begin
            ang  = (HALF_PI_Q30 * longint'(n)) / COS_TABLE_DEPTH;
            ang2 = (ang * ang) >>> 30;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int k = 1; k <= 7; k++)
            begin
                den  = longint'((2 * k - 1) * (2 * k));
                term = div_floor(term * ang2, den) / ONE_Q30;
                if ((k & 1) != 0)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            if (sum < 0)
                sum = 0;
            if (sum > ONE_Q30)
                sum = ONE_Q30;
            tbl[n] = COS_W'((sum + 64'sd16384) >>> 15);
        end
        return tbl;
    endfunction

    localparam cos_table_t COS_TABLE = build_cos_table();

endpackage

/* rtl/whvg_in_if.sv */
interface whvg_in_if import whvg_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  grid_column;
    logic [ROW_W-1:0]  grid_row;
    logic [TIME_W-1:0] elapsed_time;

    modport source (output valid, grid_column, grid_row, elapsed_time, input ready);
    modport sink   (input valid, grid_column, grid_row, elapsed_time, output ready);
endinterface

/* rtl/whvg_out_if.sv */
interface whvg_out_if import whvg_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [Y_W-1:0]   pos_y;
    logic signed [POS_W-1:0] pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

/* rtl/wave_height_vertex_generator.sv */
// Wave height vertex generator: each request carries a grid column, a grid row and an
// elapsed time, and produces one vertex on a centered regular grid with x and z in
// Q12.4 and a height y in Q9.8 that is the sum of two travelling cosine waves,
// amp * cos(kx*x + kz*z - w*t), with phases in 16-bit wrapping turns and the cosine
// taken from a quarter-wave table. The block is a six-stage pipeline and takes one
// request every cycle while grid.ready is high; each accepted request moves through the
// stage registers in order into the output register, where its vertex waits until the output side is ready.
// Stages hold their contents under back-pressure and
// empty stages still fill, so grid.ready drops only when every stage holds a vertex
// and the output register is not being taken. Configuration registers are written
// through cfg_write/cfg_index/cfg_data and must only change while no vertex is in
// flight.
module wave_height_vertex_generator import whvg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    whvg_in_if.sink               grid,
    whvg_out_if.source            vertex
);

    // Configuration registers.
    logic [AMP_W-1:0]      amp1_reg;
    logic [AMP_W-1:0]      amp2_reg;
    logic signed [K_W-1:0] kx1_reg;
    logic signed [K_W-1:0] kz1_reg;
    logic signed [K_W-1:0] kx2_reg;
    logic signed [K_W-1:0] kz2_reg;
    logic signed [K_W-1:0] w1_reg;
    logic signed [K_W-1:0] w2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp1_reg <= RST_AMPLITUDE_FIRST;
            amp2_reg <= RST_AMPLITUDE_SECOND;
            kx1_reg  <= RST_DIRECTION_X_FIRST;
            kz1_reg  <= RST_DIRECTION_Z_FIRST;
            kx2_reg  <= RST_DIRECTION_X_SECOND;
            kz2_reg  <= RST_DIRECTION_Z_SECOND;
            w1_reg   <= RST_SPEED_FIRST;
            w2_reg   <= RST_SPEED_SECOND;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_AMPLITUDE_FIRST:    amp1_reg <= cfg_data[AMP_W-1:0];
                REG_AMPLITUDE_SECOND:   amp2_reg <= cfg_data[AMP_W-1:0];
                REG_DIRECTION_X_FIRST:  kx1_reg  <= cfg_data[K_W-1:0];
                REG_DIRECTION_Z_FIRST:  kz1_reg  <= cfg_data[K_W-1:0];
                REG_DIRECTION_X_SECOND: kx2_reg  <= cfg_data[K_W-1:0];
                REG_DIRECTION_Z_SECOND: kz2_reg  <= cfg_data[K_W-1:0];
                REG_SPEED_FIRST:        w1_reg   <= cfg_data[K_W-1:0];
                REG_SPEED_SECOND:       w2_reg   <= cfg_data[K_W-1:0];
            endcase
        end
    end

    // Pipeline flow control. A stage loads when it is empty or when the stage
    // after it loads, so bubbles are squeezed out under back-pressure.
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] load;

    always_comb
    begin
        load[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || vertex.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            load[k] = !valid_reg[k] || load[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (load[0])
                valid_reg[0] <= grid.valid;
            for (int k = 1; k < PIPE_STAGES; k++)
                if (load[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign grid.ready = load[0];

    // Stage 1: clamp the indices and place the vertex on the centered grid.
    localparam logic signed [XCALC_W-1:0] POS_MAX = XCALC_W'(32767);
    localparam logic signed [XCALC_W-1:0] POS_MIN = -XCALC_W'(32768);

    logic signed [XCALC_W-1:0] col_s;
    logic signed [XCALC_W-1:0] row_s;
    logic signed [XCALC_W-1:0] x_full;
    logic signed [XCALC_W-1:0] z_full;
    logic signed [POS_W-1:0]   s1_x_next;
    logic signed [POS_W-1:0]   s1_z_next;

    always_comb
    begin
        col_s = XCALC_W'(grid.grid_column);
        row_s = XCALC_W'(grid.grid_row);
        if (col_s > XCALC_W'(GRID_COLS))
            col_s = XCALC_W'(GRID_COLS);
        if (row_s > XCALC_W'(GRID_ROWS))
            row_s = XCALC_W'(GRID_ROWS);
        x_full = signed'(XCALC_W'(CELL_SIZE_X)) * (col_s - signed'(XCALC_W'(GRID_COLS / 2)));
        z_full = signed'(XCALC_W'(CELL_SIZE_Z)) * (signed'(XCALC_W'(GRID_ROWS / 2)) - row_s);
        if (x_full > POS_MAX)
            s1_x_next = POS_W'(POS_MAX);
        else if (x_full < POS_MIN)
            s1_x_next = POS_W'(POS_MIN);
        else
            s1_x_next = POS_W'(x_full);
        if (z_full > POS_MAX)
            s1_z_next = POS_W'(POS_MAX);
        else if (z_full < POS_MIN)
            s1_z_next = POS_W'(POS_MIN);
        else
            s1_z_next = POS_W'(z_full);
    end

    logic signed [POS_W-1:0] s1_x_reg;
    logic signed [POS_W-1:0] s1_z_reg;
    logic [TIME_W-1:0]       s1_t_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s1_x_reg <= s1_x_next;
            s1_z_reg <= s1_z_next;
            s1_t_reg <= grid.elapsed_time;
        end
    end

    // Stage 2: the phase products. Only the bits that reach the 16-bit phase
    // fraction are kept, so the products are taken modulo their kept width.
    logic [K_W-1:0]    xs;
    logic [K_W-1:0]    zs;
    logic [TIME_W-1:0] ws1;
    logic [TIME_W-1:0] ws2;
    logic [TIME_W-1:0] tp1_full;
    logic [TIME_W-1:0] tp2_full;
    logic [K_W-1:0]    sx1_next;
    logic [K_W-1:0]    sz1_next;
    logic [K_W-1:0]    sx2_next;
    logic [K_W-1:0]    sz2_next;

    always_comb
    begin
        xs       = K_W'(s1_x_reg);
        zs       = K_W'(s1_z_reg);
        ws1      = TIME_W'(w1_reg);
        ws2      = TIME_W'(w2_reg);
        sx1_next = K_W'(kx1_reg) * xs;
        sz1_next = K_W'(kz1_reg) * zs;
        sx2_next = K_W'(kx2_reg) * xs;
        sz2_next = K_W'(kz2_reg) * zs;
        tp1_full = ws1 * s1_t_reg;
        tp2_full = ws2 * s1_t_reg;
    end

    logic signed [POS_W-1:0] s2_x_reg;
    logic signed [POS_W-1:0] s2_z_reg;
    logic [K_W-1:0]          s2_sx1_reg;
    logic [K_W-1:0]          s2_sz1_reg;
    logic [K_W-1:0]          s2_sx2_reg;
    logic [K_W-1:0]          s2_sz2_reg;
    logic [PHASE_W-1:0]      s2_tp1_reg;
    logic [PHASE_W-1:0]      s2_tp2_reg;

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s2_x_reg   <= s1_x_reg;
            s2_z_reg   <= s1_z_reg;
            s2_sx1_reg <= sx1_next;
            s2_sz1_reg <= sz1_next;
            s2_sx2_reg <= sx2_next;
            s2_sz2_reg <= sz2_next;
            s2_tp1_reg <= tp1_full[TIME_W-1:TIME_W-PHASE_W];
            s2_tp2_reg <= tp2_full[TIME_W-1:TIME_W-PHASE_W];
        end
    end

    // Stage 3: form each phase and turn it into a table address and a sign.
    // Quadrants one and three read the table mirrored; one and two negate.
    logic [K_W-1:0]     space1;
    logic [K_W-1:0]     space2;
    logic [PHASE_W-1:0] phase1;
    logic [PHASE_W-1:0] phase2;
    logic [IDXP_W-1:0]  iprod1;
    logic [IDXP_W-1:0]  iprod2;
    logic [IDX_W-1:0]   idx1;
    logic [IDX_W-1:0]   idx2;
    logic [IDX_W-1:0]   addr1_next;
    logic [IDX_W-1:0]   addr2_next;
    logic               neg1_next;
    logic               neg2_next;

    always_comb
    begin
        space1 = s2_sx1_reg + s2_sz1_reg;
        space2 = s2_sx2_reg + s2_sz2_reg;
        phase1 = space1[K_W-1:SPACE_SHIFT] - s2_tp1_reg;
        phase2 = space2[K_W-1:SPACE_SHIFT] - s2_tp2_reg;
        iprod1 = IDXP_W'(phase1[FRAC_W-1:0]) * IDXP_W'(COS_TABLE_DEPTH);
        iprod2 = IDXP_W'(phase2[FRAC_W-1:0]) * IDXP_W'(COS_TABLE_DEPTH);
        idx1   = iprod1[IDXP_W-1:FRAC_W];
        idx2   = iprod2[IDXP_W-1:FRAC_W];
        addr1_next = phase1[FRAC_W] ? (IDX_W'(COS_TABLE_DEPTH) - idx1) : idx1;
        addr2_next = phase2[FRAC_W] ? (IDX_W'(COS_TABLE_DEPTH) - idx2) : idx2;
        neg1_next  = phase1[FRAC_W] ^ phase1[FRAC_W+1];
        neg2_next  = phase2[FRAC_W] ^ phase2[FRAC_W+1];
    end

    logic signed [POS_W-1:0] s3_x_reg;
    logic signed [POS_W-1:0] s3_z_reg;
    logic [IDX_W-1:0]        s3_addr1_reg;
    logic [IDX_W-1:0]        s3_addr2_reg;
    logic                    s3_neg1_reg;
    logic                    s3_neg2_reg;

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s3_x_reg     <= s2_x_reg;
            s3_z_reg     <= s2_z_reg;
            s3_addr1_reg <= addr1_next;
            s3_addr2_reg <= addr2_next;
            s3_neg1_reg  <= neg1_next;
            s3_neg2_reg  <= neg2_next;
        end
    end

    // Stage 4: table lookup and sign.
    logic signed [COSS_W-1:0] cos1_mag;
    logic signed [COSS_W-1:0] cos2_mag;
    logic signed [COSS_W-1:0] cos1_next;
    logic signed [COSS_W-1:0] cos2_next;

    always_comb
    begin
        cos1_mag  = COSS_W'(COS_TABLE[s3_addr1_reg]);
        cos2_mag  = COSS_W'(COS_TABLE[s3_addr2_reg]);
        cos1_next = s3_neg1_reg ? -cos1_mag : cos1_mag;
        cos2_next = s3_neg2_reg ? -cos2_mag : cos2_mag;
    end

    logic signed [POS_W-1:0]  s4_x_reg;
    logic signed [POS_W-1:0]  s4_z_reg;
    logic signed [COSS_W-1:0] s4_cos1_reg;
    logic signed [COSS_W-1:0] s4_cos2_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s4_x_reg    <= s3_x_reg;
            s4_z_reg    <= s3_z_reg;
            s4_cos1_reg <= cos1_next;
            s4_cos2_reg <= cos2_next;
        end
    end

    // Stage 5: scale each wave by its amplitude.
    logic signed [PROD_W-1:0] prod1_next;
    logic signed [PROD_W-1:0] prod2_next;

    always_comb
    begin
        prod1_next = signed'({1'b0, amp1_reg}) * s4_cos1_reg;
        prod2_next = signed'({1'b0, amp2_reg}) * s4_cos2_reg;
    end

    logic signed [POS_W-1:0]  s5_x_reg;
    logic signed [POS_W-1:0]  s5_z_reg;
    logic signed [PROD_W-1:0] s5_prod1_reg;
    logic signed [PROD_W-1:0] s5_prod2_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s5_x_reg     <= s4_x_reg;
            s5_z_reg     <= s4_z_reg;
            s5_prod1_reg <= prod1_next;
            s5_prod2_reg <= prod2_next;
        end
    end

    // Stage 6: sum, round half up and drop to Q9.8. The low bits of the
    // floored quotient are simply a slice of the sum.
    logic signed [ACC_W-1:0] acc;

    always_comb
    begin
        acc = ACC_W'(s5_prod1_reg) + ACC_W'(s5_prod2_reg) + ACC_W'(ROUND_HALF);
    end

    logic signed [POS_W-1:0] out_x_reg;
    logic signed [Y_W-1:0]   out_y_reg;
    logic signed [POS_W-1:0] out_z_reg;

    always_ff @(posedge clk)
    begin
        if (load[5])
        begin
            out_x_reg <= s5_x_reg;
            out_y_reg <= acc[Y_SHIFT+Y_W-1:Y_SHIFT];
            out_z_reg <= s5_z_reg;
        end
    end

    assign vertex.valid = valid_reg[PIPE_STAGES-1];
    assign vertex.pos_x = out_x_reg;
    assign vertex.pos_y = out_y_reg;
    assign vertex.pos_z = out_z_reg;

endmodule

/* rtl/whvg_checker.sv */
module whvg_checker import whvg_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [POS_W-1:0] pos_x,
    input logic signed [Y_W-1:0]   pos_y,
    input logic signed [POS_W-1:0] pos_z
);

    localparam int CNT_W  = $clog2(PIPE_STAGES + 1);
    localparam int X_LO_R = -CELL_SIZE_X * (GRID_COLS / 2);
    localparam int X_HI_R = CELL_SIZE_X * (GRID_COLS - GRID_COLS / 2);
    localparam int Z_LO_R = CELL_SIZE_Z * (GRID_ROWS / 2 - GRID_ROWS);
    localparam int Z_HI_R = CELL_SIZE_Z * (GRID_ROWS / 2);
    localparam int X_LO   = (X_LO_R < -32768) ? -32768 : X_LO_R;
    localparam int X_HI   = (X_HI_R > 32767) ? 32767 : X_HI_R;
    localparam int Z_LO   = (Z_LO_R < -32768) ? -32768 : Z_LO_R;
    localparam int Z_HI   = (Z_HI_R > 32767) ? 32767 : Z_HI_R;

    // Requests accepted whose vertex has not yet been taken.
    logic [CNT_W-1:0] pending_reg;
    logic             in_take;
    logic             out_take;

    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (in_take && !out_take)
            pending_reg <= pending_reg + CNT_W'(1);
        else if (!in_take && out_take)
            pending_reg <= pending_reg - CNT_W'(1);
    end

    // A vertex held for the sink keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
            && $stable(pos_z))
        else $error("vertex changed while stalled");

    // Every vertex traces back to an accepted request.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("vertex without a request");

    // No more requests in flight than the pipeline holds.
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= CNT_W'(PIPE_STAGES))
        else $error("more requests in flight than pipeline stages");

    // Positions stay on the clamped grid.
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(pos_x) >= X_LO && int'(pos_x) <= X_HI)
        else $error("pos_x off the grid");

    a_z_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int'(pos_z) >= Z_LO && int'(pos_z) <= Z_HI)
        else $error("pos_z off the grid");

endmodule

bind wave_height_vertex_generator whvg_checker u_whvg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (grid.valid),
    .in_ready  (grid.ready),
    .out_valid (vertex.valid),
    .out_ready (vertex.ready),
    .pos_x     (vertex.pos_x),
    .pos_y     (vertex.pos_y),
    .pos_z     (vertex.pos_z)
);
